// ===== rtl/bc_pkg.sv =====
`timescale 1ns / 1ps

package bc_pkg;

    // Coordinate and weight formats.
    localparam int CRD_W  = 16;
    localparam int NCRD   = 3;
    localparam int PKD_W  = NCRD * CRD_W;
    localparam int FRAC_W = 24;
    localparam int WGT_W  = 32;
    localparam int EPS_W  = 31;

    // Exact intermediate widths.
    localparam int DIF_W  = CRD_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int DOT_W  = PRD_W + 2;
    localparam int HALF_W = DOT_W / 2;
    localparam int WPR_W  = 2 * DOT_W;
    localparam int NUM_W  = WPR_W + 1;
    localparam int OVF_SH = WGT_W - FRAC_W;
    localparam int XW     = WGT_W + 2;

    // Pipeline depths.
    localparam int FRONT_LAT = 3;
    localparam int MUL_LAT   = 2;
    localparam int DIV_LAT   = WGT_W + 2;
    localparam int DEG_STG   = FRONT_LAT + MUL_LAT;
    localparam int PIPE_LAT  = FRONT_LAT + MUL_LAT + 1 + DIV_LAT + 2;

    localparam logic CMD_SEG = 1'b0;
    localparam logic CMD_TRI = 1'b1;

    typedef logic signed [CRD_W-1:0] t_crd;
    typedef logic signed [DIF_W-1:0] t_dif;
    typedef logic signed [PRD_W-1:0] t_prd;
    typedef logic signed [DOT_W-1:0] t_dot;
    typedef logic signed [WPR_W-1:0] t_wpr;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic signed [WGT_W-1:0] t_wgt;
    typedef logic signed [XW-1:0]    t_wx;

    typedef struct packed {
        t_dot d1;
        t_dot d2;
        t_dot d3;
        t_dot d4;
        t_dot d5;
    } t_dots;

    localparam t_wx ONE_X = XW'(1) << FRAC_W;
    localparam t_wx WMAX_X = {2'b00, 1'b0, {(WGT_W-1){1'b1}}};
    localparam t_wx WMIN_X = {2'b11, 1'b1, {(WGT_W-1){1'b0}}};

    function automatic t_crd crd(logic [PKD_W-1:0] v, int k);
        return t_crd'(v[k*CRD_W +: CRD_W]);
    endfunction

    function automatic t_dif dif(t_crd a, t_crd b);
        return DIF_W'(a) - DIF_W'(b);
    endfunction

    function automatic t_wgt sat_wgt(t_wx x);
        t_wgt r;
        if (x > WMAX_X) begin
            r = WMAX_X[WGT_W-1:0];
        end else if (x < WMIN_X) begin
            r = WMIN_X[WGT_W-1:0];
        end else begin
            r = x[WGT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/bc_front.sv =====
`timescale 1ns / 1ps

module bc_front (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_cmd,
    input  logic [bc_pkg::PKD_W-1:0]  i_point_xyz,
    input  logic [bc_pkg::PKD_W-1:0]  i_corner_a_xyz,
    input  logic [bc_pkg::PKD_W-1:0]  i_corner_b_xyz,
    input  logic [bc_pkg::PKD_W-1:0]  i_corner_c_xyz,
    output bc_pkg::t_dots             o_dots
);

    bc_pkg::t_dif n_e0 [bc_pkg::NCRD];
    bc_pkg::t_dif n_e1 [bc_pkg::NCRD];
    bc_pkg::t_dif n_e2 [bc_pkg::NCRD];
    bc_pkg::t_dif r_e0 [bc_pkg::NCRD];
    bc_pkg::t_dif r_e1 [bc_pkg::NCRD];
    bc_pkg::t_dif r_e2 [bc_pkg::NCRD];
    logic         r_a_cmd;
    logic         r_b_cmd;

    bc_pkg::t_prd r_m1 [bc_pkg::NCRD];
    bc_pkg::t_prd r_m2 [bc_pkg::NCRD];
    bc_pkg::t_prd r_m3 [bc_pkg::NCRD];
    bc_pkg::t_prd r_m4 [bc_pkg::NCRD];
    bc_pkg::t_prd r_m5 [bc_pkg::NCRD];

    bc_pkg::t_dots r_dots;

    always_comb begin
        for (int k = 0; k < bc_pkg::NCRD; k++) begin
            if (i_cmd == bc_pkg::CMD_TRI) begin
                n_e0[k] = bc_pkg::dif(bc_pkg::crd(i_point_xyz, k),
                                      bc_pkg::crd(i_corner_c_xyz, k));
                n_e1[k] = bc_pkg::dif(bc_pkg::crd(i_corner_a_xyz, k),
                                      bc_pkg::crd(i_corner_c_xyz, k));
                n_e2[k] = bc_pkg::dif(bc_pkg::crd(i_corner_b_xyz, k),
                                      bc_pkg::crd(i_corner_c_xyz, k));
            end else begin
                n_e0[k] = bc_pkg::dif(bc_pkg::crd(i_point_xyz, k),
                                      bc_pkg::crd(i_corner_b_xyz, k));
                n_e1[k] = bc_pkg::dif(bc_pkg::crd(i_corner_a_xyz, k),
                                      bc_pkg::crd(i_corner_b_xyz, k));
                n_e2[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cmd <= i_cmd;
            r_b_cmd <= r_a_cmd;
            for (int k = 0; k < bc_pkg::NCRD; k++) begin
                r_e0[k] <= n_e0[k];
                r_e1[k] <= n_e1[k];
                r_e2[k] <= n_e2[k];
                r_m1[k] <= r_e0[k] * r_e1[k];
                r_m2[k] <= r_e1[k] * r_e1[k];
                r_m3[k] <= r_e2[k] * r_e1[k];
                r_m4[k] <= r_e0[k] * r_e2[k];
                r_m5[k] <= r_e2[k] * r_e2[k];
            end
            r_dots.d1 <= bc_pkg::DOT_W'(r_m1[0]) + bc_pkg::DOT_W'(r_m1[1])
                       + bc_pkg::DOT_W'(r_m1[2]);
            r_dots.d2 <= bc_pkg::DOT_W'(r_m2[0]) + bc_pkg::DOT_W'(r_m2[1])
                       + bc_pkg::DOT_W'(r_m2[2]);
            r_dots.d3 <= bc_pkg::DOT_W'(r_m3[0]) + bc_pkg::DOT_W'(r_m3[1])
                       + bc_pkg::DOT_W'(r_m3[2]);
            r_dots.d4 <= bc_pkg::DOT_W'(r_m4[0]) + bc_pkg::DOT_W'(r_m4[1])
                       + bc_pkg::DOT_W'(r_m4[2]);
            // In segment mode d3 and d4 are zero; forcing d5 to one makes the
            // shared products yield den = d2 and the u numerator = d1.
            if (r_b_cmd == bc_pkg::CMD_TRI) begin
                r_dots.d5 <= bc_pkg::DOT_W'(r_m5[0]) + bc_pkg::DOT_W'(r_m5[1])
                           + bc_pkg::DOT_W'(r_m5[2]);
            end else begin
                r_dots.d5 <= bc_pkg::DOT_W'(1);
            end
        end
    end

    assign o_dots = r_dots;

endmodule

// ===== rtl/bc_wmul.sv =====
`timescale 1ns / 1ps

module bc_wmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  bc_pkg::t_dot  i_a,
    input  bc_pkg::t_dot  i_b,
    output bc_pkg::t_wpr  o_p
);

    logic signed [bc_pkg::HALF_W-1:0]   a_hi;
    logic signed [bc_pkg::HALF_W-1:0]   b_hi;
    logic        [bc_pkg::HALF_W-1:0]   a_lo;
    logic        [bc_pkg::HALF_W-1:0]   b_lo;
    logic signed [2*bc_pkg::HALF_W-1:0] r_hh;
    logic signed [2*bc_pkg::HALF_W:0]   r_hl;
    logic signed [2*bc_pkg::HALF_W:0]   r_lh;
    logic        [2*bc_pkg::HALF_W-1:0] r_ll;
    logic        [bc_pkg::WPR_W-1:0]    n_p;
    bc_pkg::t_wpr                       r_p;

    assign a_hi = i_a[bc_pkg::DOT_W-1:bc_pkg::HALF_W];
    assign b_hi = i_b[bc_pkg::DOT_W-1:bc_pkg::HALF_W];
    assign a_lo = i_a[bc_pkg::HALF_W-1:0];
    assign b_lo = i_b[bc_pkg::HALF_W-1:0];

    // Partial sums are formed modulo 2^WPR_W; the exact product fits there.
    always_comb begin
        n_p = (bc_pkg::WPR_W'(r_hh) << (2 * bc_pkg::HALF_W))
            + ((bc_pkg::WPR_W'(r_hl) + bc_pkg::WPR_W'(r_lh)) << bc_pkg::HALF_W)
            + bc_pkg::WPR_W'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * $signed({1'b0, b_lo});
            r_lh <= $signed({1'b0, a_lo}) * b_hi;
            r_ll <= a_lo * b_lo;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/bc_div.sv =====
`timescale 1ns / 1ps

module bc_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  bc_pkg::t_num  i_num,
    input  bc_pkg::t_num  i_den,
    output bc_pkg::t_wgt  o_quo
);

    localparam int QB = bc_pkg::WGT_W;

    logic [bc_pkg::NUM_W-1:0]  n_nmag;
    logic [bc_pkg::NUM_W-1:0]  n_dmag;
    logic                      n_ovf;

    logic [bc_pkg::NUM_W-1:0]  r_rem [0:QB];
    logic [bc_pkg::NUM_W-1:0]  r_den [0:QB];
    logic [bc_pkg::OVF_SH-1:0] r_lo  [0:QB];
    logic [QB-1:0]             r_q   [0:QB];
    logic                      r_neg [0:QB];
    logic                      r_ovf [0:QB];

    logic [QB-1:0]             lim;
    logic [QB-1:0]             mag;
    bc_pkg::t_wgt              r_quo;

    always_comb begin
        n_nmag = i_num[bc_pkg::NUM_W-1] ? bc_pkg::NUM_W'(-i_num) : bc_pkg::NUM_W'(i_num);
        n_dmag = i_den[bc_pkg::NUM_W-1] ? bc_pkg::NUM_W'(-i_den) : bc_pkg::NUM_W'(i_den);
        // A quotient of 2^WGT_W or more saturates; the step result is then unused.
        n_ovf  = (bc_pkg::NUM_W + bc_pkg::OVF_SH)'(n_nmag)
               >= {n_dmag, {bc_pkg::OVF_SH{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= bc_pkg::NUM_W'(n_nmag >> bc_pkg::OVF_SH);
            r_den[0] <= n_dmag;
            r_lo[0]  <= n_nmag[bc_pkg::OVF_SH-1:0];
            r_q[0]   <= '0;
            r_neg[0] <= i_num[bc_pkg::NUM_W-1] ^ i_den[bc_pkg::NUM_W-1];
            r_ovf[0] <= n_ovf;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        logic                     fb;
        logic [bc_pkg::NUM_W:0]   sh;
        logic [bc_pkg::NUM_W:0]   df;
        logic                     ge;
        logic [QB-1:0]            nq;

        if (B >= bc_pkg::FRAC_W) begin : g_fb
            assign fb = r_lo[k][B - bc_pkg::FRAC_W];
        end else begin : g_zero
            assign fb = 1'b0;
        end

        always_comb begin
            sh    = {r_rem[k], fb};
            df    = sh - {1'b0, r_den[k]};
            ge    = sh >= {1'b0, r_den[k]};
            nq    = r_q[k];
            nq[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? df[bc_pkg::NUM_W-1:0] : sh[bc_pkg::NUM_W-1:0];
                r_den[k+1] <= r_den[k];
                r_lo[k+1]  <= r_lo[k];
                r_q[k+1]   <= nq;
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        lim = r_neg[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
        mag = (r_ovf[QB] || (r_q[QB] > lim)) ? lim : r_q[QB];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_neg[QB] ? -mag : mag;
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== rtl/barycentric_coordinates.sv =====
`timescale 1ns / 1ps
// Barycentric weights of a point against a segment (cmd 0) or a triangle (cmd 1).
// Input channel: i_valid with o_stall; a beat carries the command, the point and
// the three corners as packed signed Q8.8 coordinates. Output channel: o_valid
// with i_stall; a beat carries weights u, v, w (signed Q8.24, saturated), the
// inside flag and the degenerate flag.
// Configuration: i_cfg_valid / o_cfg_ready write the expansion tolerance
// epsilon (unsigned Q7.24); o_cfg_ready is always high. Write it while idle.
// Throughput: one item per cycle while o_stall is low. The depth comes mostly
// from the two division pipelines, one quotient bit per stage over 32 stages.
// Reset clears all valid bits, the holding register's full flag and epsilon.
// When the receiver stalls, the last result moves into a holding register and
// the pipeline keeps taking one more beat; o_stall rises the cycle after, and
// the whole pipeline then freezes until the held result is taken. No beat is
// lost or repeated.

module barycentric_coordinates (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [bc_pkg::PKD_W-1:0]          i_point_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_a_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_b_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_c_xyz,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [bc_pkg::WGT_W-1:0]   o_weight_u,
    output logic signed [bc_pkg::WGT_W-1:0]   o_weight_v,
    output logic signed [bc_pkg::WGT_W-1:0]   o_weight_w,
    output logic                              o_inside_res,
    output logic                              o_degenerate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bc_pkg::EPS_W-1:0]          i_cfg_data
);

    typedef struct packed {
        logic vld;
        logic cmd;
        logic deg;
    } t_tag;

    t_tag                    r_tag [0:bc_pkg::PIPE_LAT-1];
    logic                    en;
    logic [bc_pkg::EPS_W-1:0] r_eps;

    bc_pkg::t_dots           dots;
    bc_pkg::t_wpr            p_d2d5;
    bc_pkg::t_wpr            p_d3d3;
    bc_pkg::t_wpr            p_d1d5;
    bc_pkg::t_wpr            p_d3d4;
    bc_pkg::t_wpr            p_d2d4;
    bc_pkg::t_wpr            p_d1d3;

    bc_pkg::t_num            n_den;
    bc_pkg::t_num            r_den;
    bc_pkg::t_num            r_nu;
    bc_pkg::t_num            r_nv;
    bc_pkg::t_wgt            quo_u;
    bc_pkg::t_wgt            quo_v;

    bc_pkg::t_wgt            r_e_u;
    bc_pkg::t_wgt            r_e_v;
    bc_pkg::t_wgt            r_e_w;

    bc_pkg::t_wgt            r_f_u;
    bc_pkg::t_wgt            r_f_v;
    bc_pkg::t_wgt            r_f_w;
    logic                    r_f_in;
    logic                    r_f_dg;

    logic                    r_skid_full;
    bc_pkg::t_wgt            r_s_u;
    bc_pkg::t_wgt            r_s_v;
    bc_pkg::t_wgt            r_s_w;
    logic                    r_s_in;
    logic                    r_s_dg;

    function automatic logic not_below(bc_pkg::t_wgt x, logic [bc_pkg::EPS_W-1:0] e);
        bc_pkg::t_wx s;
        s = bc_pkg::XW'(x) + $signed(bc_pkg::XW'(e));
        return !s[bc_pkg::XW-1];
    endfunction

    assign en          = !r_skid_full;
    assign o_stall     = r_skid_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bc_pkg::PIPE_LAT; s++) begin
                r_tag[s] <= '0;
            end
        end else if (en) begin
            r_tag[0] <= '{vld: i_valid, cmd: i_cmd, deg: 1'b0};
            for (int s = 1; s < bc_pkg::PIPE_LAT; s++) begin
                if (s == bc_pkg::DEG_STG) begin
                    r_tag[s] <= '{vld: r_tag[s-1].vld, cmd: r_tag[s-1].cmd,
                                  deg: (n_den == '0)};
                end else begin
                    r_tag[s] <= r_tag[s-1];
                end
            end
        end
    end

    bc_front u_front (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_cmd          (i_cmd),
        .i_point_xyz    (i_point_xyz),
        .i_corner_a_xyz (i_corner_a_xyz),
        .i_corner_b_xyz (i_corner_b_xyz),
        .i_corner_c_xyz (i_corner_c_xyz),
        .o_dots         (dots)
    );

    bc_wmul u_mul_d2d5 (.i_clk(i_clk), .i_en(en), .i_a(dots.d2), .i_b(dots.d5), .o_p(p_d2d5));
    bc_wmul u_mul_d3d3 (.i_clk(i_clk), .i_en(en), .i_a(dots.d3), .i_b(dots.d3), .o_p(p_d3d3));
    bc_wmul u_mul_d1d5 (.i_clk(i_clk), .i_en(en), .i_a(dots.d1), .i_b(dots.d5), .o_p(p_d1d5));
    bc_wmul u_mul_d3d4 (.i_clk(i_clk), .i_en(en), .i_a(dots.d3), .i_b(dots.d4), .o_p(p_d3d4));
    bc_wmul u_mul_d2d4 (.i_clk(i_clk), .i_en(en), .i_a(dots.d2), .i_b(dots.d4), .o_p(p_d2d4));
    bc_wmul u_mul_d1d3 (.i_clk(i_clk), .i_en(en), .i_a(dots.d1), .i_b(dots.d3), .o_p(p_d1d3));

    assign n_den = bc_pkg::NUM_W'(p_d2d5) - bc_pkg::NUM_W'(p_d3d3);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= n_den;
            r_nu  <= bc_pkg::NUM_W'(p_d1d5) - bc_pkg::NUM_W'(p_d3d4);
            r_nv  <= bc_pkg::NUM_W'(p_d2d4) - bc_pkg::NUM_W'(p_d1d3);
        end
    end

    bc_div u_div_u (.i_clk(i_clk), .i_en(en), .i_num(r_nu), .i_den(r_den), .o_quo(quo_u));
    bc_div u_div_v (.i_clk(i_clk), .i_en(en), .i_num(r_nv), .i_den(r_den), .o_quo(quo_v));

    // The dependent weight comes from the already saturated quotients.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_u <= quo_u;
            if (r_tag[bc_pkg::PIPE_LAT-3].cmd == bc_pkg::CMD_TRI) begin
                r_e_v <= quo_v;
                r_e_w <= bc_pkg::sat_wgt(bc_pkg::ONE_X - bc_pkg::XW'(quo_u)
                                         - bc_pkg::XW'(quo_v));
            end else begin
                r_e_v <= bc_pkg::sat_wgt(bc_pkg::ONE_X - bc_pkg::XW'(quo_u));
                r_e_w <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_tag[bc_pkg::PIPE_LAT-2].deg) begin
                r_f_u  <= '0;
                r_f_v  <= '0;
                r_f_w  <= '0;
                r_f_in <= 1'b0;
                r_f_dg <= 1'b1;
            end else begin
                r_f_u  <= r_e_u;
                r_f_v  <= r_e_v;
                r_f_w  <= r_e_w;
                r_f_in <= not_below(r_e_u, r_eps) && not_below(r_e_v, r_eps)
                          && not_below(r_e_w, r_eps);
                r_f_dg <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (!i_stall) begin
                r_skid_full <= 1'b0;
            end
        end else if (r_tag[bc_pkg::PIPE_LAT-1].vld && i_stall) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full) begin
            r_s_u  <= r_f_u;
            r_s_v  <= r_f_v;
            r_s_w  <= r_f_w;
            r_s_in <= r_f_in;
            r_s_dg <= r_f_dg;
        end
    end

    assign o_valid      = r_skid_full || r_tag[bc_pkg::PIPE_LAT-1].vld;
    assign o_weight_u   = r_skid_full ? r_s_u  : r_f_u;
    assign o_weight_v   = r_skid_full ? r_s_v  : r_f_v;
    assign o_weight_w   = r_skid_full ? r_s_w  : r_f_w;
    assign o_inside_res = r_skid_full ? r_s_in : r_f_in;
    assign o_degenerate = r_skid_full ? r_s_dg : r_f_dg;

endmodule

// ===== rtl/bc_checker.sv =====
`timescale 1ns / 1ps

module bc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [bc_pkg::PKD_W-1:0]          i_point_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_a_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_b_xyz,
    input  logic [bc_pkg::PKD_W-1:0]          i_corner_c_xyz,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic signed [bc_pkg::WGT_W-1:0]   o_weight_u,
    input  logic signed [bc_pkg::WGT_W-1:0]   o_weight_v,
    input  logic signed [bc_pkg::WGT_W-1:0]   o_weight_w,
    input  logic                              o_inside_res,
    input  logic                              o_degenerate,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [bc_pkg::EPS_W-1:0]          i_cfg_data
);

    // A stalled result beat stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_weight_u) && $stable(o_weight_v)
            && $stable(o_weight_w) && $stable(o_inside_res) && $stable(o_degenerate))
        else $error("stalled result beat changed");

    // A degenerate result carries zero weights and is never inside.
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_weight_u == '0 && o_weight_v == '0
            && o_weight_w == '0 && !o_inside_res)
        else $error("degenerate result with nonzero weights or inside set");

    // Back-pressure upstream only ever follows a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // Once the receiver takes the held beat, the input side is released.
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall held after the result was taken");

endmodule

bind barycentric_coordinates bc_checker u_bc_checker (.*);

// ===== bench/barycentric_coordinates_tb.sv =====
`timescale 1ns / 1ps

module barycentric_coordinates_tb;

    typedef struct {
        bc_pkg::t_wgt u;
        bc_pkg::t_wgt v;
        bc_pkg::t_wgt w;
        logic         ins;
        logic         deg;
    } t_weights;

    typedef struct {
        logic                     cmd;
        logic [bc_pkg::PKD_W-1:0] p;
        logic [bc_pkg::PKD_W-1:0] a;
        logic [bc_pkg::PKD_W-1:0] b;
        logic [bc_pkg::PKD_W-1:0] c;
        logic                     typed;
        t_weights                 want;
    } t_query;

    localparam int N_RANDOM    = 800;
    localparam int N_QUIET     = 120;
    localparam int CYCLE_CAP   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam bc_pkg::t_wgt W_ONE = 32'sh0100_0000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_cmd;
    logic [bc_pkg::PKD_W-1:0]    i_point_xyz;
    logic [bc_pkg::PKD_W-1:0]    i_corner_a_xyz;
    logic [bc_pkg::PKD_W-1:0]    i_corner_b_xyz;
    logic [bc_pkg::PKD_W-1:0]    i_corner_c_xyz;
    logic                        o_valid;
    logic                        i_stall;
    bc_pkg::t_wgt                o_weight_u;
    bc_pkg::t_wgt                o_weight_v;
    bc_pkg::t_wgt                o_weight_w;
    logic                        o_inside_res;
    logic                        o_degenerate;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [bc_pkg::EPS_W-1:0]    i_cfg_data;

    t_weights                 pending_weights[$];
    t_query                   directed_rows[$];
    logic [bc_pkg::EPS_W-1:0] eps_shadow = '0;
    int                       accepted_cnt = 0;
    int                       error_cnt = 0;
    int                       cycle_cnt = 0;
    bit                       quiet = 1'b0;
    bit                       hold_done = 1'b0;

    barycentric_coordinates u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_point_xyz    (i_point_xyz),
        .i_corner_a_xyz (i_corner_a_xyz),
        .i_corner_b_xyz (i_corner_b_xyz),
        .i_corner_c_xyz (i_corner_c_xyz),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_weight_u     (o_weight_u),
        .o_weight_v     (o_weight_v),
        .o_weight_w     (o_weight_w),
        .o_inside_res   (o_inside_res),
        .o_degenerate   (o_degenerate),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    function automatic logic [bc_pkg::PKD_W-1:0] xyz(logic [15:0] x, logic [15:0] y,
                                                     logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Scaled quotient truncated toward zero, then clamped to the weight range.
    function automatic longint scaled_quotient(logic signed [127:0] num,
                                               logic signed [127:0] den);
        logic         neg;
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        logic [127:0] lim;
        neg = num[127] ^ den[127];
        an  = num[127] ? -num : num;
        ad  = den[127] ? -den : den;
        an  = an << bc_pkg::FRAC_W;
        q   = an / ad;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -longint'({32'b0, q[31:0]}) : longint'({32'b0, q[31:0]});
    endfunction

    function automatic t_weights barycentric_weights(t_query qr,
                                                     logic [bc_pkg::EPS_W-1:0] eps);
        t_weights            r;
        bc_pkg::t_crd        pc, ac, bc, cc;
        logic signed [17:0]  e0[3];
        logic signed [17:0]  e1[3];
        logic signed [17:0]  e2[3];
        logic signed [127:0] d1, d2, d3, d4, d5, den;
        longint              u, v, w, neps;
        u = 0; v = 0; w = 0;
        d1 = '0; d2 = '0; d3 = '0; d4 = '0; d5 = '0;
        for (int k = 0; k < 3; k++) begin
            pc = qr.p[k*bc_pkg::CRD_W +: bc_pkg::CRD_W];
            ac = qr.a[k*bc_pkg::CRD_W +: bc_pkg::CRD_W];
            bc = qr.b[k*bc_pkg::CRD_W +: bc_pkg::CRD_W];
            cc = qr.c[k*bc_pkg::CRD_W +: bc_pkg::CRD_W];
            if (qr.cmd == bc_pkg::CMD_SEG) begin
                e1[k] = ac - bc;
                e0[k] = pc - bc;
                e2[k] = '0;
            end else begin
                e0[k] = pc - cc;
                e1[k] = ac - cc;
                e2[k] = bc - cc;
            end
            d1 += e0[k] * e1[k];
            d2 += e1[k] * e1[k];
            d3 += e2[k] * e1[k];
            d4 += e0[k] * e2[k];
            d5 += e2[k] * e2[k];
        end
        if (qr.cmd == bc_pkg::CMD_SEG) begin
            den = d2;
            r.deg = (den == '0);
            if (!r.deg) begin
                u = scaled_quotient(d1, den);
                v = clamp32(longint'(W_ONE) - u);
            end
        end else begin
            den = d2 * d5 - d3 * d3;
            r.deg = (den == '0);
            if (!r.deg) begin
                u = scaled_quotient(d1 * d5 - d3 * d4, den);
                v = scaled_quotient(d2 * d4 - d1 * d3, den);
                w = clamp32(longint'(W_ONE) - u - v);
            end
        end
        neps  = -longint'({33'b0, eps});
        r.ins = !r.deg && u >= neps && v >= neps && w >= neps;
        r.u = bc_pkg::t_wgt'(u);
        r.v = bc_pkg::t_wgt'(v);
        r.w = bc_pkg::t_wgt'(w);
        return r;
    endfunction

    task automatic add_row(logic cmd, logic [bc_pkg::PKD_W-1:0] p,
                           logic [bc_pkg::PKD_W-1:0] a, logic [bc_pkg::PKD_W-1:0] b,
                           logic [bc_pkg::PKD_W-1:0] c, logic typed,
                           bc_pkg::t_wgt u, bc_pkg::t_wgt v, bc_pkg::t_wgt w,
                           logic ins, logic deg);
        t_query qr;
        qr.cmd = cmd; qr.p = p; qr.a = a; qr.b = b; qr.c = c; qr.typed = typed;
        qr.want.u = u; qr.want.v = v; qr.want.w = w;
        qr.want.ins = ins; qr.want.deg = deg;
        directed_rows.push_back(qr);
    endtask

    // A row whose expectation comes from the predictor.
    task automatic add_free(logic cmd, logic [bc_pkg::PKD_W-1:0] p,
                            logic [bc_pkg::PKD_W-1:0] a, logic [bc_pkg::PKD_W-1:0] b,
                            logic [bc_pkg::PKD_W-1:0] c);
        add_row(cmd, p, a, b, c, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    endtask

    function automatic logic [15:0] pick_coord(int style);
        logic [15:0] edges[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0100};
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1024)) - 16'd512;
            default: return edges[$urandom_range(0, 5)];
        endcase
    endfunction

    function automatic t_query random_query();
        t_query                   qr;
        int                       style;
        int                       shape;
        logic [bc_pkg::PKD_W-1:0] corners[4];
        style = $urandom_range(0, 9);
        shape = (style < 4) ? 0 : (style < 8) ? 1 : 2;
        for (int i = 0; i < 4; i++)
            corners[i] = xyz(pick_coord(shape), pick_coord(shape), pick_coord(shape));
        qr.cmd = 1'($urandom_range(0, 1));
        qr.p = corners[0]; qr.a = corners[1]; qr.b = corners[2]; qr.c = corners[3];
        case ($urandom_range(0, 11))
            0: qr.b = qr.a;
            1: begin qr.b = qr.a; qr.c = qr.a; end
            2: qr.p = qr.c;
            3: qr.p = qr.a;
            // Collinear corners make the triangle degenerate.
            4: begin
                qr.a = xyz(16'd0, 16'd0, 16'd0);
                qr.b = xyz(16'd100, 16'd200, 16'hFFF0);
                qr.c = xyz(16'd300, 16'd600, 16'hFFD0);
            end
            default: ;
        endcase
        qr.typed = 1'b0;
        return qr;
    endfunction

    task automatic send_query(t_query qr);
        t_weights expd;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= qr.cmd;
        i_point_xyz    <= qr.p;
        i_corner_a_xyz <= qr.a;
        i_corner_b_xyz <= qr.b;
        i_corner_c_xyz <= qr.c;
        do @(posedge i_clk); while (o_stall);
        if (qr.typed) begin
            expd = qr.want;
        end else begin
            expd = barycentric_weights(qr, eps_shadow);
        end
        pending_weights.push_back(expd);
        accepted_cnt++;
        @(negedge i_clk);
    endtask

    task automatic write_epsilon(logic [bc_pkg::EPS_W-1:0] value);
        i_valid <= 1'b0;
        wait (pending_weights.size() == 0);
        repeat (bc_pkg::PIPE_LAT + 5) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        eps_shadow = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_weights expd;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_weights.size() == 0) begin
                $display("%0t: result beat with nothing expected: u=%h v=%h w=%h",
                         $time, o_weight_u, o_weight_v, o_weight_w);
                error_cnt++;
            end else begin
                expd = pending_weights.pop_front();
                if (o_weight_u !== expd.u || o_weight_v !== expd.v ||
                    o_weight_w !== expd.w || o_inside_res !== expd.ins ||
                    o_degenerate !== expd.deg) begin
                    $display("%0t: expected u=%h v=%h w=%h ins=%b deg=%b",
                             $time, expd.u, expd.v, expd.w, expd.ins, expd.deg);
                    $display("%0t: actual   u=%h v=%h w=%h ins=%b deg=%b",
                             $time, o_weight_u, o_weight_v, o_weight_w,
                             o_inside_res, o_degenerate);
                    error_cnt++;
                end
            end
        end
    end

    // Receiver stalls in bursts; once, a long hold-off fills the pipeline.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && !hold_done && accepted_cnt >= 400) begin
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_done = 1'b1;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [bc_pkg::EPS_W-1:0] eps_plan[4];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = 1'b0;
        i_point_xyz = '0;
        i_corner_a_xyz = '0;
        i_corner_b_xyz = '0;
        i_corner_c_xyz = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;

        // Rows with a typed expectation: degenerate cases and points on a corner.
        add_row(bc_pkg::CMD_SEG, xyz(16'h0010, 16'h0, 16'h0),
                xyz(16'h0100, 16'h0200, 16'h0), xyz(16'h0100, 16'h0200, 16'h0), '0,
                1'b1, '0, '0, '0, 1'b0, 1'b1);
        add_row(bc_pkg::CMD_SEG, xyz(16'h0100, 16'h0, 16'h0),
                xyz(16'h0100, 16'h0, 16'h0), '0, '0,
                1'b1, W_ONE, '0, '0, 1'b1, 1'b0);
        add_row(bc_pkg::CMD_SEG, '0, xyz(16'h0100, 16'h0, 16'h0), '0, '0,
                1'b1, '0, W_ONE, '0, 1'b1, 1'b0);
        add_row(bc_pkg::CMD_TRI, xyz(16'h0005, 16'h0, 16'h0),
                xyz(16'h0100, 16'h0100, 16'h0100), xyz(16'h0100, 16'h0100, 16'h0100),
                xyz(16'h0100, 16'h0100, 16'h0100),
                1'b1, '0, '0, '0, 1'b0, 1'b1);
        add_row(bc_pkg::CMD_TRI, xyz(16'h0100, 16'h0, 16'h0),
                xyz(16'h0100, 16'h0, 16'h0), xyz(16'h0, 16'h0100, 16'h0), '0,
                1'b1, W_ONE, '0, '0, 1'b1, 1'b0);
        add_row(bc_pkg::CMD_TRI, '0, xyz(16'h0100, 16'h0, 16'h0),
                xyz(16'h0, 16'h0100, 16'h0), '0,
                1'b1, '0, '0, W_ONE, 1'b1, 1'b0);
        // Extremes, saturation and ordinary points, checked by prediction.
        add_free(bc_pkg::CMD_SEG, xyz(16'h7FFF, 16'h7FFF, 16'h7FFF),
                 xyz(16'h0001, 16'h0, 16'h0), '0, '0);
        add_free(bc_pkg::CMD_SEG, xyz(16'h8000, 16'h8000, 16'h8000),
                 xyz(16'h0001, 16'h0, 16'h0), '0, '0);
        add_free(bc_pkg::CMD_SEG, '1, {3{16'h7FFF}}, {3{16'h8000}}, '1);
        add_free(bc_pkg::CMD_SEG, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, '0);
        add_free(bc_pkg::CMD_TRI, {3{16'h7FFF}}, {3{16'h8000}},
                 xyz(16'h7FFF, 16'h8000, 16'h0), xyz(16'h8000, 16'h7FFF, 16'h7FFF));
        add_free(bc_pkg::CMD_TRI, xyz(16'h7FFF, 16'h8000, 16'h0),
                 xyz(16'h0001, 16'h0, 16'h0), xyz(16'h0, 16'h0001, 16'h0), '0);
        add_free(bc_pkg::CMD_TRI, xyz(16'h0040, 16'h0040, 16'h0),
                 xyz(16'h0100, 16'h0, 16'h0), xyz(16'h0, 16'h0100, 16'h0), '0);
        add_free(bc_pkg::CMD_TRI, xyz(16'hFFF0, 16'h0040, 16'h0),
                 xyz(16'h0100, 16'h0, 16'h0), xyz(16'h0, 16'h0100, 16'h0), '0);
        add_free(bc_pkg::CMD_TRI, '1, '1, '0, {3{16'h5555}});
        add_free(bc_pkg::CMD_SEG, xyz(16'h0080, 16'h0001, 16'h0),
                 xyz(16'h0100, 16'h0, 16'h0), '0, {3{16'hAAAA}});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_epsilon('0);
        foreach (directed_rows[i]) send_query(directed_rows[i]);

        eps_plan = '{31'h7FFF_FFFF, 31'h0010_0000, 31'h0, 31'h0};
        eps_plan[3] = bc_pkg::EPS_W'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            write_epsilon(eps_plan[ph]);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if (ph == 3 && n >= N_RANDOM / 4 - N_QUIET) quiet = 1'b1;
                send_query(random_query());
            end
        end
        i_valid <= 1'b0;

        wait (pending_weights.size() == 0);
        repeat (bc_pkg::PIPE_LAT + 10) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
